// File: rtl/core/pfde_pkg.sv
`timescale 1ns / 1ps
package pfde_pkg;

   localparam int SCREEN_COLUMNS = 128;
   localparam int SCREEN_ROWS    = 64;

   localparam int PAGE_COUNT  = (SCREEN_ROWS + 7) / 8;
   localparam int STORE_BYTES = SCREEN_COLUMNS * PAGE_COUNT;
   localparam int ADDR_W      = $clog2(STORE_BYTES);
   localparam int PAGE_W      = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
   localparam int COL_W       = (SCREEN_COLUMNS > 1) ? $clog2(SCREEN_COLUMNS) : 1;
   // wide enough for any coordinate compare against the screen limits
   localparam int CNT_W       = 9;

   localparam logic [1:0] OP_VLINE = 2'd0;
   localparam logic [1:0] OP_BAND  = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] x_pos;
      logic [7:0] y_pos;
      logic [7:0] line_height;
      logic [7:0] column_bits;
      logic       ink;
      logic [2:0] read_page;
   } pfde_req_type;

   typedef struct packed {
      logic load;
      logic clear_step;
      logic mem_read;
      logic mem_write;
      logic capture;
      logic next_page;
      logic out_load;
   } pfde_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic skip;
      logic is_read;
      logic at_end;
      logic out_free;
   } pfde_stat_type;

endpackage

// File: rtl/core/pfde_req_if.sv
`timescale 1ns / 1ps
interface pfde_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] operation;
   logic [7:0] x_pos;
   logic [7:0] y_pos;
   logic [7:0] line_height;
   logic [7:0] column_bits;
   logic       ink;
   logic [2:0] read_page;

   modport source (
      output valid, operation, x_pos, y_pos, line_height, column_bits, ink, read_page,
      input  ready
   );
   modport sink (
      input  valid, operation, x_pos, y_pos, line_height, column_bits, ink, read_page,
      output ready
   );
endinterface

// File: rtl/core/pfde_rsp_if.sv
`timescale 1ns / 1ps
interface pfde_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic       status;

   modport source (
      output valid, read_data, status,
      input  ready
   );
   modport sink (
      input  valid, read_data, status,
      output ready
   );
endinterface

// File: rtl/core/pfde_ram.sv
`timescale 1ns / 1ps
module pfde_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     enable,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] address,
   input  logic [WIDTH-1:0]         write_data,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         if (write_enable) begin
            store_ff[address] <= write_data;
         end else begin
            read_data_ff <= store_ff[address];
         end
      end
   end

   assign read_data = read_data_ff;

endmodule

// File: rtl/core/pfde_ctrl.sv
`timescale 1ns / 1ps
module pfde_ctrl
   import pfde_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  pfde_stat_type stat,
   output pfde_cmd_type  cmd
);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_CHECK = 3'd2;
   localparam logic [2:0] S_READ  = 3'd3;
   localparam logic [2:0] S_WRITE = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            state_in = stat.skip ? S_DONE : S_READ;
         end
         S_READ: begin
            cmd.mem_read = 1'b1;
            state_in     = S_WRITE;
         end
         S_WRITE: begin
            // read data from the store is valid here
            if (stat.is_read) begin
               cmd.capture = 1'b1;
               state_in    = S_DONE;
            end else begin
               cmd.mem_write = 1'b1;
               if (stat.at_end) begin
                  state_in = S_DONE;
               end else begin
                  cmd.next_page = 1'b1;
                  state_in      = S_READ;
               end
            end
         end
         S_DONE: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

endmodule

// File: rtl/core/pfde_datapath.sv
`timescale 1ns / 1ps
module pfde_datapath
   import pfde_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  pfde_req_type  req,
   input  pfde_cmd_type  cmd,
   output pfde_stat_type stat,
   input  logic          rsp_ready,
   output logic          rsp_valid,
   output logic [7:0]    rsp_read_data,
   output logic          rsp_status
);

   // load-time decode
   logic [CNT_W-1:0]  x9, y9, h9, rows_left, h_eff, last_row;
   logic              x_off, y_off, rp_off, status_in, skip_in, band_next;
   logic [2:0]        shift;
   logic [PAGE_W-1:0] first_page_in, last_page_in, end_page_in, cur_page_in;
   logic [15:0]       shifted;

   // item registers
   logic              is_read_ff, is_band_ff, ink_ff, skip_ff, res_status_ff;
   logic [COL_W-1:0]  x_ff;
   logic [PAGE_W-1:0] cur_page_ff, first_page_ff, end_page_ff;
   logic [7:0]        first_mask_ff, last_mask_ff, band_lo_ff, band_hi_ff, res_data_ff;

   // clearing pass and output register
   logic [ADDR_W-1:0] clr_ff;
   logic              out_valid_ff, out_status_ff;
   logic [7:0]        out_data_ff;

   logic [7:0]        mask, mem_rdata, mem_wdata, merged;
   logic [ADDR_W-1:0] page_addr, mem_addr;

   always_comb begin
      x9        = {1'b0, req.x_pos};
      y9        = {1'b0, req.y_pos};
      h9        = {1'b0, req.line_height};
      x_off     = x9 >= CNT_W'(SCREEN_COLUMNS);
      y_off     = y9 >= CNT_W'(SCREEN_ROWS);
      rp_off    = {6'd0, req.read_page} >= CNT_W'(PAGE_COUNT);
      rows_left = CNT_W'(SCREEN_ROWS) - y9;
      h_eff     = (h9 > rows_left) ? rows_left : h9;
      last_row  = y9 + h_eff - CNT_W'(1);
      shift     = req.y_pos[2:0];
      shifted   = {8'h00, req.column_bits} << shift;

      first_page_in = PAGE_W'(req.y_pos >> 3);
      last_page_in  = PAGE_W'(last_row >> 3);
      band_next     = (CNT_W'(first_page_in) + CNT_W'(1)) < CNT_W'(PAGE_COUNT);

      case (req.operation)
         OP_VLINE: begin
            status_in   = x_off | y_off;
            end_page_in = last_page_in;
         end
         OP_BAND: begin
            status_in   = x_off | y_off;
            // high byte dropped when there is no page below
            end_page_in = band_next ? (first_page_in + PAGE_W'(1)) : first_page_in;
         end
         OP_READ: begin
            status_in   = x_off | rp_off;
            end_page_in = first_page_in;
         end
         default: begin
            status_in   = 1'b1;
            end_page_in = first_page_in;
         end
      endcase

      skip_in     = status_in | ((req.operation == OP_VLINE) && (h_eff == '0));
      cur_page_in = (req.operation == OP_READ) ? PAGE_W'(req.read_page) : first_page_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         is_read_ff    <= (req.operation == OP_READ);
         is_band_ff    <= (req.operation == OP_BAND);
         ink_ff        <= req.ink;
         skip_ff       <= skip_in;
         res_status_ff <= status_in;
         res_data_ff   <= 8'h00;
         x_ff          <= COL_W'(req.x_pos);
         first_page_ff <= first_page_in;
         end_page_ff   <= end_page_in;
         first_mask_ff <= 8'hFF << shift;
         last_mask_ff  <= 8'hFF >> (3'd7 - last_row[2:0]);
         band_lo_ff    <= shifted[7:0];
         band_hi_ff    <= shifted[15:8];
      end
      if (cmd.capture) begin
         res_data_ff <= mem_rdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cur_page_ff <= cur_page_in;
      end else if (cmd.next_page) begin
         cur_page_ff <= cur_page_ff + PAGE_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_ff <= clr_ff + ADDR_W'(1);
      end
   end

   always_comb begin
      if (is_band_ff) begin
         mask = (cur_page_ff == first_page_ff) ? band_lo_ff : band_hi_ff;
      end else begin
         mask = ((cur_page_ff == first_page_ff) ? first_mask_ff : 8'hFF) &
                ((cur_page_ff == end_page_ff) ? last_mask_ff : 8'hFF);
      end
      merged    = ink_ff ? (mem_rdata | mask) : (mem_rdata & ~mask);
      page_addr = ADDR_W'(cur_page_ff) * ADDR_W'(SCREEN_COLUMNS) + ADDR_W'(x_ff);
      mem_addr  = cmd.clear_step ? clr_ff : page_addr;
      mem_wdata = cmd.clear_step ? 8'h00 : merged;
   end

   pfde_ram #(
      .WIDTH (8),
      .DEPTH (STORE_BYTES)
   ) u_store (
      .clock        (clock),
      .enable       (cmd.clear_step | cmd.mem_read | cmd.mem_write),
      .write_enable (cmd.clear_step | cmd.mem_write),
      .address      (mem_addr),
      .write_data   (mem_wdata),
      .read_data    (mem_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_data_ff   <= res_data_ff;
         out_status_ff <= res_status_ff;
      end
   end

   assign stat.clear_last = (clr_ff == ADDR_W'(STORE_BYTES - 1));
   assign stat.skip       = skip_ff;
   assign stat.is_read    = is_read_ff;
   assign stat.at_end     = (cur_page_ff == end_page_ff);
   assign stat.out_free   = ~out_valid_ff | rsp_ready;

   assign rsp_valid     = out_valid_ff;
   assign rsp_read_data = out_data_ff;
   assign rsp_status    = out_status_ff;

endmodule

// File: rtl/core/page_framebuffer_draw_engine_top.sv
`timescale 1ns / 1ps
// monochrome page frame store with a vertical line writer, a band column
// writer and a byte reader
// req_bus: valid/ready channel carrying one draw or read item
// rsp_bus: valid/ready channel, exactly one result item per request item
// after reset the store is swept to zero, one byte a cycle, over all
// STORE_BYTES bytes (1024 at 128 x 64); req_bus.ready stays low during the sweep
// each page a line or band touches is a read then a write of the single-port
// store, and a read item only reads its one page; a skipped item (off-screen,
// unknown or a zero-height line) touches no page and goes straight to its
// result; the next item can be taken in the cycle after the result is registered
// the result sits in an output register; a new item is accepted while it
// waits, and that item's result is held until the receiver takes the old one
// a stalled receiver never loses or repeats a result
module page_framebuffer_draw_engine_top
   import pfde_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   pfde_req_if.sink   req_bus,
   pfde_rsp_if.source rsp_bus
);

   pfde_req_type  req_item;
   pfde_cmd_type  cmd;
   pfde_stat_type stat;

   assign req_item.operation   = req_bus.operation;
   assign req_item.x_pos       = req_bus.x_pos;
   assign req_item.y_pos       = req_bus.y_pos;
   assign req_item.line_height = req_bus.line_height;
   assign req_item.column_bits = req_bus.column_bits;
   assign req_item.ink         = req_bus.ink;
   assign req_item.read_page   = req_bus.read_page;

   pfde_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   pfde_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req           (req_item),
      .cmd           (cmd),
      .stat          (stat),
      .rsp_ready     (rsp_bus.ready),
      .rsp_valid     (rsp_bus.valid),
      .rsp_read_data (rsp_bus.read_data),
      .rsp_status    (rsp_bus.status)
   );

endmodule

// File: tb/pfde_frame_checker.sv
`timescale 1ns / 1ps
module pfde_frame_checker
   import pfde_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   pfde_req_if        req_mon,
   pfde_rsp_if        rsp_mon,
   output int         mismatch_count,
   output int         pending_count,
   output int         checked_count
);

   typedef struct packed {
      logic [7:0] read_data;
      logic       status;
   } frame_result_type;

   logic [7:0]       shadow_store [STORE_BYTES];
   frame_result_type expected_results [$];
   int               errors;
   int               compared;

   function automatic void paint_byte(int unsigned page, int unsigned col,
                                      logic [7:0] mask, logic ink);
      int unsigned slot;
      // pages or columns past the edge are dropped
      if (page >= PAGE_COUNT || col >= SCREEN_COLUMNS) return;
      slot = page * SCREEN_COLUMNS + col;
      if (ink) shadow_store[slot] = shadow_store[slot] | mask;
      else shadow_store[slot] = shadow_store[slot] & ~mask;
   endfunction

   function automatic frame_result_type predict_item(pfde_req_type item);
      frame_result_type outcome;
      int unsigned      col;
      int unsigned      row;
      int unsigned      height;
      int unsigned      shift;
      int unsigned      page;
      logic [15:0]      spread;
      outcome = '0;
      col     = 32'(item.x_pos);
      row     = 32'(item.y_pos);
      shift   = row % 8;
      page    = row / 8;
      case (item.operation)
         OP_VLINE, OP_BAND: begin
            if (col >= SCREEN_COLUMNS || row >= SCREEN_ROWS) begin
               outcome.status = 1'b1;
            end else if (item.operation == OP_VLINE) begin
               height = 32'(item.line_height);
               // crop at the bottom edge
               if (row + height > SCREEN_ROWS) height = SCREEN_ROWS - row;
               if (height != 0) begin
                  if (height <= 8 - shift) begin
                     paint_byte(page, col, 8'(((1 << height) - 1) << shift), item.ink);
                  end else begin
                     paint_byte(page, col, 8'(32'hff << shift), item.ink);
                     height -= 8 - shift;
                     while (height > 8) begin
                        page++;
                        paint_byte(page, col, 8'hff, item.ink);
                        height -= 8;
                     end
                     paint_byte(page + 1, col, 8'((1 << height) - 1), item.ink);
                  end
               end
            end else begin
               spread = 16'(item.column_bits) << shift;
               paint_byte(page, col, spread[7:0], item.ink);
               paint_byte(page + 1, col, spread[15:8], item.ink);
            end
         end
         OP_READ: begin
            if (col >= SCREEN_COLUMNS || item.read_page >= PAGE_COUNT) begin
               outcome.status = 1'b1;
            end else begin
               outcome.read_data = shadow_store[item.read_page * SCREEN_COLUMNS + col];
            end
         end
         default: begin
            outcome.status = 1'b1;
         end
      endcase
      return outcome;
   endfunction

   always @(posedge clock) begin
      pfde_req_type     req_item;
      frame_result_type got;
      frame_result_type want;
      if (reset) begin
         for (int i = 0; i < STORE_BYTES; i++) shadow_store[i] = 8'h00;
         expected_results.delete();
      end else begin
         // results first, so an item taken on the same edge is never matched
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.read_data = rsp_mon.read_data;
            got.status    = rsp_mon.status;
            if (expected_results.size() == 0) begin
               $error("unexpected result item: read_data %h status %0b",
                      got.read_data, got.status);
               errors++;
            end else begin
               want = expected_results.pop_front();
               compared++;
               if (got.read_data !== want.read_data) begin
                  $error("read_data: expected %h, got %h", want.read_data, got.read_data);
                  errors++;
               end
               if (got.status !== want.status) begin
                  $error("status: expected %0b, got %0b", want.status, got.status);
                  errors++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            req_item.operation   = req_mon.operation;
            req_item.x_pos       = req_mon.x_pos;
            req_item.y_pos       = req_mon.y_pos;
            req_item.line_height = req_mon.line_height;
            req_item.column_bits = req_mon.column_bits;
            req_item.ink         = req_mon.ink;
            req_item.read_page   = req_mon.read_page;
            expected_results.push_back(predict_item(req_item));
         end
      end
      mismatch_count <= errors;
      pending_count  <= expected_results.size();
      checked_count  <= compared;
   end

endmodule

// File: tb/page_framebuffer_draw_engine_top_tb.sv
`timescale 1ns / 1ps
module page_framebuffer_draw_engine_top_tb;
   import pfde_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int PHASE_ITEMS    = 165;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 40;

   logic clock = 1'b0;
   logic reset;
   int   sender_idle_pct;
   int   receiver_stall_pct;
   int   items_sent;
   int   idle_cycles;
   int   mismatch_count;
   int   pending_count;
   int   checked_count;

   pfde_req_if req_bus();
   pfde_rsp_if rsp_bus();

   page_framebuffer_draw_engine_top i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   pfde_frame_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .checked_count  (checked_count)
   );

   always #2 clock = ~clock;

   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   // counts cycles with no item moving on either channel
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic pfde_req_type make_item(logic [1:0] op, logic [7:0] x, logic [7:0] y,
                                              logic [7:0] h, logic [7:0] bits, logic ink,
                                              logic [2:0] page);
      pfde_req_type item;
      item.operation   = op;
      item.x_pos       = x;
      item.y_pos       = y;
      item.line_height = h;
      item.column_bits = bits;
      item.ink         = ink;
      item.read_page   = page;
      return item;
   endfunction

   task automatic send_item(input pfde_req_type item);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.operation   <= item.operation;
      req_bus.x_pos       <= item.x_pos;
      req_bus.y_pos       <= item.y_pos;
      req_bus.line_height <= item.line_height;
      req_bus.column_bits <= item.column_bits;
      req_bus.ink         <= item.ink;
      req_bus.read_page   <= item.read_page;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
   endtask

   initial begin
      pfde_req_type item;
      int           pick;
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.operation   <= OP_VLINE;
      req_bus.x_pos       <= '0;
      req_bus.y_pos       <= '0;
      req_bus.line_height <= '0;
      req_bus.column_bits <= '0;
      req_bus.ink         <= 1'b0;
      req_bus.read_page   <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: cleared store, aligned page, cropping, edges, band spill
      send_item(make_item(OP_READ,  8'd0,   8'd0,   8'd0,   8'h00, 1'b0, 3'd0));
      send_item(make_item(OP_VLINE, 8'd0,   8'd0,   8'd8,   8'h00, 1'b1, 3'd0));
      send_item(make_item(OP_READ,  8'd0,   8'd0,   8'd0,   8'h00, 1'b0, 3'd0));
      send_item(make_item(OP_VLINE, 8'd127, 8'd0,   8'd255, 8'h00, 1'b1, 3'd0));
      send_item(make_item(OP_READ,  8'd127, 8'd0,   8'd0,   8'h00, 1'b0, 3'd7));
      send_item(make_item(OP_VLINE, 8'd127, 8'd5,   8'd20,  8'h00, 1'b0, 3'd0));
      send_item(make_item(OP_READ,  8'd127, 8'd0,   8'd0,   8'h00, 1'b0, 3'd0));
      send_item(make_item(OP_READ,  8'd127, 8'd0,   8'd0,   8'h00, 1'b0, 3'd3));
      send_item(make_item(OP_VLINE, 8'd1,   8'd3,   8'd2,   8'h00, 1'b1, 3'd0));
      send_item(make_item(OP_VLINE, 8'd1,   8'd63,  8'd1,   8'h00, 1'b1, 3'd0));
      send_item(make_item(OP_READ,  8'd1,   8'd0,   8'd0,   8'h00, 1'b0, 3'd7));
      send_item(make_item(OP_VLINE, 8'd2,   8'd10,  8'd0,   8'h00, 1'b1, 3'd0));
      send_item(make_item(OP_VLINE, 8'd128, 8'd0,   8'd8,   8'h00, 1'b1, 3'd0));
      send_item(make_item(OP_VLINE, 8'd0,   8'd64,  8'd8,   8'h00, 1'b1, 3'd0));
      send_item(make_item(OP_VLINE, 8'd255, 8'd255, 8'd255, 8'hff, 1'b1, 3'd7));
      send_item(make_item(OP_BAND,  8'd10,  8'd0,   8'd0,   8'hff, 1'b1, 3'd0));
      send_item(make_item(OP_BAND,  8'd10,  8'd13,  8'd0,   8'ha5, 1'b1, 3'd0));
      send_item(make_item(OP_READ,  8'd10,  8'd0,   8'd0,   8'h00, 1'b0, 3'd2));
      send_item(make_item(OP_BAND,  8'd10,  8'd60,  8'd0,   8'hff, 1'b1, 3'd0));
      send_item(make_item(OP_READ,  8'd10,  8'd0,   8'd0,   8'h00, 1'b0, 3'd7));
      send_item(make_item(OP_BAND,  8'd10,  8'd3,   8'd0,   8'h0f, 1'b0, 3'd0));
      send_item(make_item(OP_READ,  8'd10,  8'd0,   8'd0,   8'h00, 1'b0, 3'd0));
      send_item(make_item(OP_BAND,  8'd128, 8'd0,   8'd0,   8'hff, 1'b1, 3'd0));
      send_item(make_item(OP_READ,  8'd255, 8'd0,   8'd0,   8'h00, 1'b0, 3'd7));
      send_item(make_item(OP_UNUSED, 8'd0,  8'd0,   8'd0,   8'h00, 1'b0, 3'd0));

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 70; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 70; end
            default: begin sender_idle_pct = 9; receiver_stall_pct = 9; end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(0, 19);
            if (pick < 7) item.operation = OP_VLINE;
            else if (pick < 14) item.operation = OP_BAND;
            else if (pick < 19) item.operation = OP_READ;
            else item.operation = OP_UNUSED;
            // keep most items on a few columns so reads see earlier drawing
            pick = $urandom_range(0, 9);
            if (pick < 5) item.x_pos = 8'($urandom_range(0, 7));
            else if (pick < 8) item.x_pos = 8'($urandom_range(0, SCREEN_COLUMNS - 1));
            else if (pick < 9)
               item.x_pos = 8'($urandom_range(SCREEN_COLUMNS - 8, SCREEN_COLUMNS - 1));
            else item.x_pos = 8'($urandom_range(SCREEN_COLUMNS, 255));
            if ($urandom_range(0, 9) < 9) item.y_pos = 8'($urandom_range(0, SCREEN_ROWS - 1));
            else item.y_pos = 8'($urandom_range(SCREEN_ROWS, 255));
            if ($urandom_range(0, 1)) item.line_height = 8'($urandom_range(0, 12));
            else item.line_height = 8'($urandom_range(0, 255));
            item.column_bits = 8'($urandom_range(0, 255));
            item.ink         = ($urandom_range(0, 99) < 55);
            item.read_page   = 3'($urandom_range(0, 7));
            send_item(item);
         end
         req_bus.valid <= 1'b0;
         @(posedge clock);
         // hold off until every expected result is back
         while (pending_count != 0) @(posedge clock);
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("run: %0d items sent over four idle and stall phases, %0d results compared",
               items_sent, checked_count);
      $display("run: lines, bands, reads, off-screen and unknown operations all exercised");
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// File: page_framebuffer_draw_engine_top.f
rtl/core/pfde_pkg.sv
rtl/core/pfde_req_if.sv
rtl/core/pfde_rsp_if.sv
rtl/core/pfde_ram.sv
rtl/core/pfde_ctrl.sv
rtl/core/pfde_datapath.sv
rtl/core/page_framebuffer_draw_engine_top.sv
tb/pfde_frame_checker.sv
tb/page_framebuffer_draw_engine_top_tb.sv
